>>> rtl/core/depth_to_color_registration_defines.svh
// Assertion helpers for the registration RTL.
`ifndef DEPTH_TO_COLOR_REGISTRATION_DEFINES_SVH
`define DEPTH_TO_COLOR_REGISTRATION_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define D2C_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen.
`define D2C_ASSERT_NEVER(lbl, cond, msg) \
	`D2C_ASSERT(lbl, !(cond), msg)

`endif

>>> rtl/core/d2c_pkg.sv
`default_nettype none
package d2c_pkg;

	localparam int COL_IN_W = 10;
	localparam int ROW_IN_W = 9;
	localparam int DEPTH_W = 16;
	localparam int COEF_W = 32;
	localparam int LIN_W = 44;	// coef*col + coef*row + offset
	localparam int NUM_W = 61;	// lin*depth + inv*65535
	localparam int QUO_W = NUM_W - 1 - 16;	// |num| >> 16
	localparam int CFG_IDX_W = 4;
	localparam int NUM_REGS = 8;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_COL_TO_X = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_TO_X = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_TO_X = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_COL_TO_Y = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_ROW_TO_Y = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DEPTH_TO_Y = 4'd7;

	localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd65536;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_col_to_x;
		logic signed [COEF_W-1:0] coef_row_to_x;
		logic signed [COEF_W-1:0] offset_x;
		logic signed [COEF_W-1:0] inv_depth_to_x;
		logic signed [COEF_W-1:0] coef_col_to_y;
		logic signed [COEF_W-1:0] coef_row_to_y;
		logic signed [COEF_W-1:0] offset_y;
		logic signed [COEF_W-1:0] inv_depth_to_y;
	} d2c_cfg_t;

	// One classified pixel handed from front to back.
	typedef struct packed {
		logic frame_start;
		logic has_depth;
		logic signed [NUM_W-1:0] num_x;
		logic signed [NUM_W-1:0] num_y;
		logic [DEPTH_W-1:0] depth;
	} d2c_job_t;

endpackage
`default_nettype wire

>>> rtl/core/d2c_front.sv
`default_nettype none
module d2c_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire d2c_pkg::d2c_cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_frame_start,
	input wire logic [d2c_pkg::COL_IN_W-1:0] in_col,
	input wire logic [d2c_pkg::ROW_IN_W-1:0] in_row,
	input wire logic [d2c_pkg::DEPTH_W-1:0] in_depth,
	output logic push,
	input wire logic full,
	output d2c_pkg::d2c_job_t job
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL = 5'b00010,
		F_SUM = 5'b00100,
		F_SCALE = 5'b01000,
		F_PUSH = 5'b10000
	} fstate_t;

	fstate_t state_q;
	logic fs_q;
	logic [d2c_pkg::COL_IN_W-1:0] col_q;
	logic [d2c_pkg::ROW_IN_W-1:0] row_q;
	logic [d2c_pkg::DEPTH_W-1:0] depth_q;
	logic signed [d2c_pkg::LIN_W-1:0] pxc_q, pxr_q, pyc_q, pyr_q;
	logic signed [d2c_pkg::LIN_W-1:0] lin_x_q, lin_y_q;
	logic signed [d2c_pkg::NUM_W-1:0] prod_x_q, prod_y_q, inv_x_q, inv_y_q;
	logic signed [d2c_pkg::LIN_W-1:0] col_s, row_s;
	logic signed [d2c_pkg::NUM_W-1:0] dep_s, ivx_s, ivy_s;

	assign in_ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH) && !full;

	assign col_s = d2c_pkg::LIN_W'($signed({1'b0, col_q}));
	assign row_s = d2c_pkg::LIN_W'($signed({1'b0, row_q}));
	assign dep_s = d2c_pkg::NUM_W'($signed({1'b0, depth_q}));
	assign ivx_s = d2c_pkg::NUM_W'(cfg.inv_depth_to_x);
	assign ivy_s = d2c_pkg::NUM_W'(cfg.inv_depth_to_y);

	always_comb begin
		job.frame_start = fs_q;
		job.has_depth = (depth_q != '0);
		job.num_x = prod_x_q + inv_x_q;
		job.num_y = prod_y_q + inv_y_q;
		job.depth = depth_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) state_q <= (in_depth == '0) ? F_PUSH : F_MUL;
				F_MUL: state_q <= F_SUM;
				F_SUM: state_q <= F_SCALE;
				F_SCALE: state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fs_q <= in_frame_start;
			col_q <= in_col;
			row_q <= in_row;
			depth_q <= in_depth;
		end
		pxc_q <= d2c_pkg::LIN_W'(cfg.coef_col_to_x) * col_s;
		pxr_q <= d2c_pkg::LIN_W'(cfg.coef_row_to_x) * row_s;
		pyc_q <= d2c_pkg::LIN_W'(cfg.coef_col_to_y) * col_s;
		pyr_q <= d2c_pkg::LIN_W'(cfg.coef_row_to_y) * row_s;
		lin_x_q <= pxc_q + pxr_q + d2c_pkg::LIN_W'(cfg.offset_x);
		lin_y_q <= pyc_q + pyr_q + d2c_pkg::LIN_W'(cfg.offset_y);
		prod_x_q <= d2c_pkg::NUM_W'(lin_x_q) * dep_s;
		prod_y_q <= d2c_pkg::NUM_W'(lin_y_q) * dep_s;
		// inv * 65535 as a shift and subtract
		inv_x_q <= (ivx_s <<< 16) - ivx_s;
		inv_y_q <= (ivy_s <<< 16) - ivy_s;
	end

endmodule
`default_nettype wire

>>> rtl/core/d2c_queue.sv
`default_nettype none
module d2c_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire d2c_pkg::d2c_job_t wdata,
	output logic full,
	input wire logic pop,
	output logic nonempty,
	output d2c_pkg::d2c_job_t rdata
);

	d2c_pkg::d2c_job_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

endmodule
`default_nettype wire

>>> rtl/core/d2c_div.sv
`default_nettype none
module d2c_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [d2c_pkg::QUO_W-1:0] dividend,
	input wire logic [d2c_pkg::DEPTH_W-1:0] divisor,
	output logic done,
	output logic [d2c_pkg::QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(d2c_pkg::QUO_W);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [d2c_pkg::QUO_W-1:0] dq_q;
	logic [d2c_pkg::DEPTH_W-1:0] rem_q, div_q;
	logic [d2c_pkg::DEPTH_W:0] trial;
	logic ge;

	assign trial = {rem_q, dq_q[d2c_pkg::QUO_W-1]};
	assign ge = (trial >= {1'b0, div_q});
	assign done = done_q;
	assign quo = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(d2c_pkg::QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q <= {dq_q[d2c_pkg::QUO_W-2:0], ge};
			rem_q <= ge ? d2c_pkg::DEPTH_W'(trial - {1'b0, div_q})
				: d2c_pkg::DEPTH_W'(trial);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/d2c_back.sv
`default_nettype none
`include "depth_to_color_registration_defines.svh"
module d2c_back #(
	parameter int FRAME_WIDTH = 640,
	parameter int FRAME_HEIGHT = 480,
	parameter int MAX_RUN = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic nonempty,
	input wire d2c_pkg::d2c_job_t job,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [d2c_pkg::COL_IN_W-1:0] out_col,
	output logic [d2c_pkg::ROW_IN_W-1:0] out_row,
	output logic [d2c_pkg::DEPTH_W-1:0] out_depth,
	output logic out_last
);

	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);
	localparam int SW = COL_W + 8;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_DIV = 4'b0010,
		B_CHECK = 4'b0100,
		B_EMIT = 4'b1000
	} bstate_t;

	bstate_t state_q;
	logic [COL_W-1:0] lwc_q, cur_q, x_q;
	logic [ROW_W-1:0] y_q;
	logic neg_x_q, neg_y_q;
	logic [d2c_pkg::DEPTH_W-1:0] depth_q;
	logic [d2c_pkg::NUM_W-1:0] mag_x, mag_y;
	logic [d2c_pkg::QUO_W-1:0] qx, qy;
	logic done_x, done_y, start_div, ok, emit;
	logic [SW-1:0] xe, le, first;
	logic out_valid_q;

	assign pop = (state_q == B_IDLE) && nonempty;
	assign start_div = pop && job.has_depth;
	assign mag_x = job.num_x[d2c_pkg::NUM_W-1] ? d2c_pkg::NUM_W'(-job.num_x) : job.num_x;
	assign mag_y = job.num_y[d2c_pkg::NUM_W-1] ? d2c_pkg::NUM_W'(-job.num_y) : job.num_y;

	d2c_div u_div_x (
		.clk(clk), .arst_n(arst_n), .start(start_div),
		.dividend(mag_x[d2c_pkg::NUM_W-2:16]), .divisor(job.depth),
		.done(done_x), .quo(qx)
	);

	d2c_div u_div_y (
		.clk(clk), .arst_n(arst_n), .start(start_div),
		.dividend(mag_y[d2c_pkg::NUM_W-2:16]), .divisor(job.depth),
		.done(done_y), .quo(qy)
	);

	// a negative truncated quotient is in range only when it is zero
	assign ok = (neg_x_q ? (qx == '0) : (qx < d2c_pkg::QUO_W'(FRAME_WIDTH)))
		&& (neg_y_q ? (qy == '0) : (qy < d2c_pkg::QUO_W'(FRAME_HEIGHT)));

	always_comb begin
		xe = SW'(neg_x_q ? '0 : qx[COL_W-1:0]);
		le = SW'(lwc_q) + SW'(1);
		if (xe > le) begin
			first = (xe + SW'(1) >= le + SW'(MAX_RUN)) ? xe + SW'(1) - SW'(MAX_RUN) : le;
		end else begin
			first = xe;
		end
	end

	assign emit = (state_q == B_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			lwc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !out_ready);
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (job.frame_start) lwc_q <= '0;
						if (job.has_depth) state_q <= B_DIV;
					end
				end
				B_DIV: if (done_x) state_q <= B_CHECK;
				B_CHECK: state_q <= ok ? B_EMIT : B_IDLE;
				B_EMIT: begin
					if (emit && cur_q == x_q) begin
						lwc_q <= x_q;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_x_q <= job.num_x[d2c_pkg::NUM_W-1];
			neg_y_q <= job.num_y[d2c_pkg::NUM_W-1];
			depth_q <= job.depth;
		end
		if (state_q == B_CHECK) begin
			cur_q <= first[COL_W-1:0];
			x_q <= xe[COL_W-1:0];
			y_q <= neg_y_q ? '0 : qy[ROW_W-1:0];
		end else if (emit) begin
			cur_q <= cur_q + 1'b1;
		end
		if (emit) begin
			out_col <= d2c_pkg::COL_IN_W'(cur_q);
			out_row <= d2c_pkg::ROW_IN_W'(y_q);
			out_depth <= depth_q;
			out_last <= (cur_q == x_q);
		end
	end

	`D2C_ASSERT(a_run_bounded, (state_q == B_EMIT) |-> (cur_q <= x_q), "run passed target column")
	`D2C_ASSERT(a_div_lockstep, done_x == done_y, "dividers out of step")
	`D2C_ASSERT_NEVER(a_pop_busy, pop && (state_q != B_IDLE), "queue popped while busy")

endmodule
`default_nettype wire

>>> rtl/core/depth_to_color_registration.sv
// Path: front states MUL, SUM, SCALE, PUSH (zero depth goes from IDLE to PUSH), back states
// IDLE, DIV (bit-serial divide), CHECK, then EMIT for the writes of the run (1 to MAX_RUN writes).
// The back works on one item at a time, paced by the bit-serial divider;
// the front fills a 2-entry queue while the back works.
// Reset (arst_n low, asynchronous): registers to identity map, last column 0,
// queue empty, no output valid.
`default_nettype none
module depth_to_color_registration #(
	parameter int FRAME_WIDTH = 640,
	parameter int FRAME_HEIGHT = 480,
	parameter int MAX_RUN = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [d2c_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [d2c_pkg::COEF_W-1:0] cfg_data,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [39:0] s_axis_tdata,	// src_col[9:0], src_row[18:10], depth[34:19]
	input wire logic s_axis_tuser,	// frame_start
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [39:0] m_axis_tdata,	// dst_col[9:0], dst_row[18:10], dst_depth[34:19]
	output logic m_axis_tlast	// run_last
);

	d2c_pkg::d2c_cfg_t cfg_q;
	d2c_pkg::d2c_job_t wjob, rjob;
	logic push, full, pop, nonempty;
	logic [d2c_pkg::COL_IN_W-1:0] o_col;
	logic [d2c_pkg::ROW_IN_W-1:0] o_row;
	logic [d2c_pkg::DEPTH_W-1:0] o_depth;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_col_to_x <= d2c_pkg::COEF_ONE;
			cfg_q.coef_row_to_x <= '0;
			cfg_q.offset_x <= '0;
			cfg_q.inv_depth_to_x <= '0;
			cfg_q.coef_col_to_y <= '0;
			cfg_q.coef_row_to_y <= d2c_pkg::COEF_ONE;
			cfg_q.offset_y <= '0;
			cfg_q.inv_depth_to_y <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				d2c_pkg::REG_COEF_COL_TO_X: cfg_q.coef_col_to_x <= cfg_data;
				d2c_pkg::REG_COEF_ROW_TO_X: cfg_q.coef_row_to_x <= cfg_data;
				d2c_pkg::REG_OFFSET_X: cfg_q.offset_x <= cfg_data;
				d2c_pkg::REG_INV_DEPTH_TO_X: cfg_q.inv_depth_to_x <= cfg_data;
				d2c_pkg::REG_COEF_COL_TO_Y: cfg_q.coef_col_to_y <= cfg_data;
				d2c_pkg::REG_COEF_ROW_TO_Y: cfg_q.coef_row_to_y <= cfg_data;
				d2c_pkg::REG_OFFSET_Y: cfg_q.offset_y <= cfg_data;
				d2c_pkg::REG_INV_DEPTH_TO_Y: cfg_q.inv_depth_to_y <= cfg_data;
				default: ;
			endcase
		end
	end

	d2c_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_frame_start(s_axis_tuser),
		.in_col(s_axis_tdata[9:0]), .in_row(s_axis_tdata[18:10]),
		.in_depth(s_axis_tdata[34:19]),
		.push(push), .full(full), .job(wjob)
	);

	d2c_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wjob), .full(full),
		.pop(pop), .nonempty(nonempty), .rdata(rjob)
	);

	d2c_back #(
		.FRAME_WIDTH(FRAME_WIDTH), .FRAME_HEIGHT(FRAME_HEIGHT), .MAX_RUN(MAX_RUN)
	) u_back (
		.clk(clk), .arst_n(arst_n), .nonempty(nonempty), .job(rjob), .pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_col(o_col), .out_row(o_row), .out_depth(o_depth), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {5'b0, o_depth, o_row, o_col};

endmodule
`default_nettype wire
